// File: rtl/core/spep_pkg.sv
// Shared types and constants for the sequencer pattern event parser.
`timescale 1ns / 1ps

package spep_pkg;

   localparam logic [1:0] KIND_REST = 2'd0;
   localparam logic [1:0] KIND_NOTE = 2'd1;
   localparam logic [1:0] KIND_PROG = 2'd2;
   localparam logic [1:0] KIND_END  = 2'd3;

   localparam logic [7:0] BYTE_END_LEAD = 8'hF0;
   localparam logic [7:0] BYTE_END_TAIL = 8'hFF;
   localparam logic [7:0] BYTE_LEN_FE   = 8'hFE;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [6:0]  note_number;
      logic [11:0] event_delay;
      logic [12:0] note_length;
      logic [7:0]  velocity;
      logic [7:0]  program_res;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// File: rtl/core/spep_parser.sv
// Byte-wise event decoder: parse phase, held fields and up to two results per beat.
`timescale 1ns / 1ps

module spep_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic                pattern_start,
   output spep_pkg::push_type  push
);

   typedef enum logic [2:0] {
      PH_START,
      PH_REST_DLY,
      PH_REST_PEEK,
      PH_NOTE_DLY,
      PH_NOTE_BYTE,
      PH_NOTE_PROG,
      PH_LEN_FIRST,
      PH_LEN_SECND
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [3:0]  velocity_ff, velocity_in;
   logic [11:0] delay_ff, delay_in;
   logic [6:0]  note_ff, note_in;
   logic [7:0]  len_high_ff, len_high_in;
   logic        endc_ff, endc_in, cur_endc;

   spep_pkg::result_type note_res;

   always_comb begin
      note_res             = '0;
      note_res.event_kind  = spep_pkg::KIND_NOTE;
      note_res.note_number = note_ff;
      note_res.event_delay = delay_ff;
      note_res.velocity    = {velocity_ff, 4'h0};
      note_res.last_of_run = 1'b1;
   end

   always_comb begin
      cur_phase   = pattern_start ? PH_START : phase_ff;
      cur_endc    = pattern_start ? 1'b0 : endc_ff;
      phase_in    = cur_phase;
      endc_in     = cur_endc;
      velocity_in = velocity_ff;
      delay_in    = delay_ff;
      note_in     = note_ff;
      len_high_in = len_high_ff;
      push        = '0;

      unique case (cur_phase)
         PH_START: begin
            if (data_byte == 8'h00) begin
               phase_in = PH_REST_DLY;
               endc_in  = 1'b0;
            end else begin
               velocity_in = data_byte[7:4];
               delay_in    = {data_byte[3:0], 8'h00};
               endc_in     = (data_byte == spep_pkg::BYTE_END_LEAD);
               phase_in    = PH_NOTE_DLY;
            end
         end
         PH_REST_DLY: begin
            delay_in = {4'h0, data_byte};
            phase_in = PH_REST_PEEK;
         end
         PH_REST_PEEK: begin
            if (data_byte[7]) begin
               push.count                    = 2'd2;
               push.first.event_kind         = spep_pkg::KIND_PROG;
               push.first.program_res        = {1'b0, data_byte[6:0]};
               push.second.event_kind        = spep_pkg::KIND_REST;
               push.second.event_delay       = delay_ff;
               push.second.last_of_run       = 1'b1;
               phase_in                      = PH_START;
            end else begin
               push.count                    = 2'd1;
               push.first.event_kind         = spep_pkg::KIND_REST;
               push.first.event_delay        = delay_ff;
               push.first.last_of_run        = 1'b1;
               if (data_byte == 8'h00) begin
                  phase_in = PH_REST_DLY;
                  endc_in  = 1'b0;
               end else begin
                  velocity_in = data_byte[7:4];
                  delay_in    = {data_byte[3:0], 8'h00};
                  endc_in     = (data_byte == spep_pkg::BYTE_END_LEAD);
                  phase_in    = PH_NOTE_DLY;
               end
            end
         end
         PH_NOTE_DLY: begin
            delay_in = {delay_ff[11:8], data_byte};
            if (data_byte != 8'h00) begin
               endc_in = 1'b0;
            end
            phase_in = PH_NOTE_BYTE;
         end
         PH_NOTE_BYTE: begin
            if (cur_endc && data_byte == spep_pkg::BYTE_END_TAIL) begin
               push.count             = 2'd1;
               push.first.event_kind  = spep_pkg::KIND_END;
               push.first.last_of_run = 1'b1;
               endc_in                = 1'b0;
               phase_in               = PH_START;
            end else begin
               endc_in  = 1'b0;
               note_in  = data_byte[6:0];
               phase_in = data_byte[7] ? PH_NOTE_PROG : PH_LEN_FIRST;
            end
         end
         PH_NOTE_PROG: begin
            push.count             = 2'd1;
            push.first.event_kind  = spep_pkg::KIND_PROG;
            push.first.program_res = data_byte;
            push.first.last_of_run = 1'b1;
            phase_in               = PH_LEN_FIRST;
         end
         PH_LEN_FIRST: begin
            if (data_byte[7]) begin
               len_high_in = data_byte;
               phase_in    = PH_LEN_SECND;
            end else begin
               push.count             = 2'd1;
               push.first             = note_res;
               push.first.note_length = {5'h00, data_byte};
               phase_in               = PH_START;
            end
         end
         PH_LEN_SECND: begin
            push.count = 2'd1;
            push.first = note_res;
            if (len_high_ff == spep_pkg::BYTE_LEN_FE) begin
               push.first.note_length = {6'h00, data_byte[6:0]};
            end else begin
               // high byte masked with 0x15: bits 4, 2, 0 land on 12, 10, 8
               push.first.note_length = {len_high_ff[4], 1'b0, len_high_ff[2], 1'b0,
                                         len_high_ff[0], data_byte};
            end
            phase_in = PH_START;
         end
         default: begin
            phase_in = PH_START;
         end
      endcase

      if (!take) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         endc_ff     <= 1'b0;
         velocity_ff <= '0;
         delay_ff    <= '0;
         note_ff     <= '0;
         len_high_ff <= '0;
      end else if (take) begin
         phase_ff    <= phase_in;
         endc_ff     <= endc_in;
         velocity_ff <= velocity_in;
         delay_ff    <= delay_in;
         note_ff     <= note_in;
         len_high_ff <= len_high_in;
      end
   end

endmodule

// File: rtl/core/spep_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one beat a cycle while out_stall is low.
`timescale 1ns / 1ps

module spep_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  spep_pkg::push_type    push,
   output logic                  full_for_two,
   output logic                  out_valid,
   input  logic                  out_stall,
   output spep_pkg::result_type  out_data
);

   spep_pkg::result_type entry_ff [spep_pkg::FIFO_DEPTH];

   logic [spep_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_next, rd_ptr_ff, rd_ptr_in;
   logic [spep_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       pop;

   assign out_valid    = (count_ff != '0);
   assign out_data     = entry_ff[rd_ptr_ff];
   assign pop          = out_valid && !out_stall;
   assign full_for_two = (count_ff > spep_pkg::CNT_W'(spep_pkg::FIFO_DEPTH - 2));
   assign wr_next      = wr_ptr_ff + spep_pkg::PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + spep_pkg::PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + spep_pkg::PTR_W'(pop);
      count_in  = count_ff + spep_pkg::CNT_W'(push.count) - spep_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// File: rtl/core/sequencer_pattern_event_parser.sv
// Top level of the sequencer pattern event parser.
//
// Usage:
//  - req_ channel carries one pattern byte a beat (req_data_byte) with
//    req_pattern_start, which puts the parser back at event start first.
//  - rsp_ channel carries one decoded event a beat; rsp_last_of_run marks
//    the final event caused by one input byte (a rest peek may give two).
//  - A beat moves when valid is high and stall is low.
//  - Latency: an event caused by a byte is offered on rsp_ at the earliest
//    the cycle after that byte is taken; a second event from it follows.
//  - Throughput: one byte a cycle, set by the four-entry result queue;
//    req_stall rises while fewer than two entries are free.
//  - Bytes that only advance the parse phase give no event.
//  - Stalling rsp_ holds the head event; the queue absorbs what follows
//    until it fills, then req_stall is raised.
//  - Reset (synchronous) empties the queue and clears phase and held fields.
`timescale 1ns / 1ps

module sequencer_pattern_event_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_pattern_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [6:0]  rsp_note_number,
   output logic [11:0] rsp_event_delay,
   output logic [12:0] rsp_note_length,
   output logic [7:0]  rsp_velocity,
   output logic [7:0]  rsp_program_res,
   output logic        rsp_last_of_run
);

   spep_pkg::push_type   push;
   spep_pkg::result_type head;
   logic                 take;
   logic                 full_for_two;

   assign req_stall = full_for_two;
   assign take      = req_valid && !full_for_two;

   spep_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .data_byte     (req_data_byte),
      .pattern_start (req_pattern_start),
      .push          (push)
   );

   spep_out_fifo u_out_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full_for_two (full_for_two),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_data     (head)
   );

   assign rsp_event_kind  = head.event_kind;
   assign rsp_note_number = head.note_number;
   assign rsp_event_delay = head.event_delay;
   assign rsp_note_length = head.note_length;
   assign rsp_velocity    = head.velocity;
   assign rsp_program_res = head.program_res;
   assign rsp_last_of_run = head.last_of_run;

endmodule

// File: tb/tb_sequencer_pattern_event_parser.sv
// Self-checking testbench for the sequencer pattern event parser.
`timescale 1ns / 1ps

module tb_sequencer_pattern_event_parser;

   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_WAIT     = 19;

   localparam logic [7:0] BYTE_REST     = 8'h00;
   localparam logic [7:0] LEN_HIGH_MASK = 8'h15;
   localparam logic [7:0] LEN_LOW_MASK  = 8'h7F;

   typedef enum logic [2:0] {
      PH_START, PH_REST_DLY, PH_REST_PEEK, PH_NOTE_DLY,
      PH_NOTE_BYTE, PH_NOTE_PROG, PH_LEN_FIRST, PH_LEN_SECND
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } pattern_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_pattern_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [6:0]  rsp_note_number;
   logic [11:0] rsp_event_delay;
   logic [12:0] rsp_note_length;
   logic [7:0]  rsp_velocity;
   logic [7:0]  rsp_program_res;
   logic        rsp_last_of_run;

   sequencer_pattern_event_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_pattern_start (req_pattern_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_note_number   (rsp_note_number),
      .rsp_event_delay   (rsp_event_delay),
      .rsp_note_length   (rsp_note_length),
      .rsp_velocity      (rsp_velocity),
      .rsp_program_res   (rsp_program_res),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   pattern_beat_type     pattern_bytes[$];
   spep_pkg::result_type expected_events[$];
   int                   errors = 0;

   parse_phase_type phase      = PH_START;
   logic [3:0]      vel_hold   = 4'h0;
   logic [11:0]     delay_hold = 12'h000;
   logic [6:0]      note_hold  = 7'h00;
   logic [7:0]      len_high   = 8'h00;
   logic            end_cand   = 1'b0;

   bit req_took  = 1'b0;
   int req_wait  = 0;
   int rsp_wait  = 0;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int idle_cycles = 0;

   task automatic queue_byte(input logic [7:0] data, input logic start);
      pattern_beat_type beat;
      beat.data  = data;
      beat.start = start;
      pattern_bytes.push_back(beat);
   endtask

   task automatic post_event(input logic [1:0] kind, input logic [6:0] note,
                             input logic [11:0] dly, input logic [12:0] len,
                             input logic [7:0] vel, input logic [7:0] prog,
                             input logic last);
      spep_pkg::result_type ev;
      ev.event_kind  = kind;
      ev.note_number = note;
      ev.event_delay = dly;
      ev.note_length = len;
      ev.velocity    = vel;
      ev.program_res = prog;
      ev.last_of_run = last;
      expected_events.push_back(ev);
   endtask

   task automatic post_note(input logic [12:0] len);
      post_event(spep_pkg::KIND_NOTE, note_hold, delay_hold, len, {vel_hold, 4'h0},
                 8'h00, 1'b1);
   endtask

   task automatic open_event(input logic [7:0] b);
      if (b == BYTE_REST) begin
         phase    = PH_REST_DLY;
         end_cand = 1'b0;
      end else begin
         vel_hold   = b[7:4];
         delay_hold = {b[3:0], 8'h00};
         end_cand   = (b == spep_pkg::BYTE_END_LEAD);
         phase      = PH_NOTE_DLY;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic start);
      if (start) begin
         phase    = PH_START;
         end_cand = 1'b0;
      end
      case (phase)
         PH_START: open_event(b);
         PH_REST_DLY: begin
            delay_hold = {4'h0, b};
            phase      = PH_REST_PEEK;
         end
         PH_REST_PEEK: begin
            if (b[7]) begin
               post_event(spep_pkg::KIND_PROG, 7'h00, 12'h000, 13'h0000, 8'h00,
                          {1'b0, b[6:0]}, 1'b0);
               post_event(spep_pkg::KIND_REST, 7'h00, delay_hold, 13'h0000, 8'h00,
                          8'h00, 1'b1);
               phase = PH_START;
            end else begin
               post_event(spep_pkg::KIND_REST, 7'h00, delay_hold, 13'h0000, 8'h00,
                          8'h00, 1'b1);
               open_event(b);
            end
         end
         PH_NOTE_DLY: begin
            delay_hold[7:0] = b;
            if (b != 8'h00) end_cand = 1'b0;
            phase = PH_NOTE_BYTE;
         end
         PH_NOTE_BYTE: begin
            if (end_cand && b == spep_pkg::BYTE_END_TAIL) begin
               post_event(spep_pkg::KIND_END, 7'h00, 12'h000, 13'h0000, 8'h00,
                          8'h00, 1'b1);
               end_cand = 1'b0;
               phase    = PH_START;
            end else begin
               end_cand  = 1'b0;
               note_hold = b[6:0];
               phase     = b[7] ? PH_NOTE_PROG : PH_LEN_FIRST;
            end
         end
         PH_NOTE_PROG: begin
            post_event(spep_pkg::KIND_PROG, 7'h00, 12'h000, 13'h0000, 8'h00, b, 1'b1);
            phase = PH_LEN_FIRST;
         end
         PH_LEN_FIRST: begin
            if (b[7]) begin
               len_high = b;
               phase    = PH_LEN_SECND;
            end else begin
               post_note({5'h00, b});
               phase = PH_START;
            end
         end
         default: begin
            if (len_high == spep_pkg::BYTE_LEN_FE)
               post_note({5'h00, b & LEN_LOW_MASK});
            else
               post_note({5'h00, b} + {(len_high[4:0] & LEN_HIGH_MASK[4:0]), 8'h00});
            phase = PH_START;
         end
      endcase
   endtask

   // driver
   always @(negedge clock) begin : driver
      pattern_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_took)) begin
         req_took = 1'b0;
         if (req_wait != 0) begin
            req_valid <= 1'b0;
            req_wait--;
         end else if (pattern_bytes.size() != 0) begin
            beat = pattern_bytes.pop_front();
            req_data_byte     <= beat.data;
            req_pattern_start <= beat.start;
            req_valid         <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= (rsp_wait != 0);
      if (rsp_wait != 0) rsp_wait--;
   end

   // monitor
   always @(posedge clock) begin : monitor
      spep_pkg::result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data_byte, req_pattern_start);
            req_took = 1'b1;
            if ($urandom_range(0, 49) == 0) req_quiet = ~req_quiet;
            req_wait = req_quiet ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (rsp_valid && !rsp_stall) begin
            if (rsp_quiet ? ($urandom_range(0, 29) == 0) : ($urandom_range(0, 49) == 0))
               rsp_quiet = ~rsp_quiet;
            rsp_wait = rsp_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (expected_events.size() == 0) begin
               $error("unexpected event beat: kind %0d", rsp_event_kind);
               errors++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_kind !== want.event_kind) begin
                  $error("event_kind: expected %0d, got %0d", want.event_kind, rsp_event_kind);
                  errors++;
               end
               if (rsp_note_number !== want.note_number) begin
                  $error("note_number: expected %0d, got %0d",
                         want.note_number, rsp_note_number);
                  errors++;
               end
               if (rsp_event_delay !== want.event_delay) begin
                  $error("event_delay: expected %0d, got %0d",
                         want.event_delay, rsp_event_delay);
                  errors++;
               end
               if (rsp_note_length !== want.note_length) begin
                  $error("note_length: expected %0d, got %0d",
                         want.note_length, rsp_note_length);
                  errors++;
               end
               if (rsp_velocity !== want.velocity) begin
                  $error("velocity: expected %0d, got %0d", want.velocity, rsp_velocity);
                  errors++;
               end
               if (rsp_program_res !== want.program_res) begin
                  $error("program_res: expected %0d, got %0d",
                         want.program_res, rsp_program_res);
                  errors++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, got %0d",
                         want.last_of_run, rsp_last_of_run);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("sequencer_pattern_event_parser verification failed");
         $finish;
      end
   end

   initial begin
      int         directed;
      int         pick;
      logic       restart;
      logic [7:0] b;

      // rest with program change peek
      queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h80, 1'b0);
      // end of track
      queue_byte(8'hF0, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b0);
      // F0 then nonzero: note, FE length form
      queue_byte(8'hF0, 1'b0); queue_byte(8'h01, 1'b0); queue_byte(8'h20, 1'b0);
      queue_byte(8'hFE, 1'b0); queue_byte(8'hFF, 1'b0);
      // F0 00 not followed by FF: note, longest length
      queue_byte(8'hF0, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h3C, 1'b0);
      queue_byte(8'h95, 1'b0); queue_byte(8'hFF, 1'b0);
      // restart mid-note, rest with plain peek, note with program byte
      queue_byte(8'h10, 1'b0); queue_byte(8'h00, 1'b1); queue_byte(8'hFF, 1'b0);
      queue_byte(8'h7F, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0); queue_byte(8'h7F, 1'b0);
      directed = pattern_bytes.size();

      while (pattern_bytes.size() < directed + RANDOM_ITEMS) begin
         restart = ($urandom_range(0, 7) == 0);
         pick    = $urandom_range(0, 99);
         if (pick < 10) begin
            queue_byte(8'($urandom), $urandom_range(0, 9) == 0);
         end else if (pick < 35) begin
            queue_byte(BYTE_REST, restart);
            queue_byte(8'($urandom), 1'b0);
            if ($urandom_range(0, 1) != 0) queue_byte(8'h80 | 8'($urandom), 1'b0);
         end else if (pick < 45) begin
            queue_byte(spep_pkg::BYTE_END_LEAD, restart);
            queue_byte(($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom), 1'b0);
            queue_byte(($urandom_range(0, 3) != 0) ? spep_pkg::BYTE_END_TAIL : 8'($urandom),
                       1'b0);
         end else begin
            b = 8'($urandom);
            if (b == BYTE_REST) b = 8'h01;
            queue_byte(b, restart);
            queue_byte(8'($urandom), 1'b0);
            b = 8'($urandom);
            queue_byte(b, 1'b0);
            if (b[7]) queue_byte(8'($urandom), 1'b0);
            b = ($urandom_range(0, 5) == 0) ? spep_pkg::BYTE_LEN_FE : 8'($urandom);
            queue_byte(b, 1'b0);
            if (b[7]) queue_byte(8'($urandom), 1'b0);
         end
      end

      rsp_wait = $urandom_range(0, MAX_WAIT);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pattern_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_events.size() != 0) begin
         $error("%0d expected events never arrived", expected_events.size());
         errors++;
      end
      if (errors == 0)
         $display("sequencer_pattern_event_parser verification clean");
      else
         $display("sequencer_pattern_event_parser verification failed");
      $finish;
   end

endmodule
